@@ rtl/core/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// ole_pkg
// Shared constants and types for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int CAPACITY = 256;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int DATA_W   = 32;

  localparam logic [3:0] A_ADD_FRONT  = 4'd0;
  localparam logic [3:0] A_ADD_BACK   = 4'd1;
  localparam logic [3:0] A_DROP_FRONT = 4'd2;
  localparam logic [3:0] A_DROP_BACK  = 4'd3;
  localparam logic [3:0] A_READ_AT    = 4'd4;
  localparam logic [3:0] A_WRITE_AT   = 4'd5;
  localparam logic [3:0] A_INSERT_AT  = 4'd6;
  localparam logic [3:0] A_REMOVE_AT  = 4'd7;
  localparam logic [3:0] A_FIND       = 4'd8;
  localparam logic [3:0] A_CLEAR      = 4'd9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_BADIDX   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

endpackage

@@ rtl/core/ole_req_if.sv @@
// ----------------------------------------------------------------------------
// ole_req_if
// Request channel: one list action per transfer.
// ----------------------------------------------------------------------------
interface ole_req_if
  import ole_pkg::*;
  ;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [7:0]  position;
  data_t       value;

  modport source (output valid, action, position, value, input ready);
  modport sink (input valid, action, position, value, output ready);
endinterface

@@ rtl/core/ole_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ole_rsp_if
// Response channel: outcome and list summary per transfer.
// ----------------------------------------------------------------------------
interface ole_rsp_if
  import ole_pkg::*;
  ;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  data_t       read_value;
  logic [7:0]  found_index;
  logic [8:0]  list_size;
  data_t       first_value;
  data_t       last_value;

  modport source (output valid, status, read_value, found_index, list_size,
                  first_value, last_value, input ready);
  modport sink (input valid, status, read_value, found_index, list_size,
                first_value, last_value, output ready);
endinterface

@@ rtl/core/ole_ram.sv @@
// ----------------------------------------------------------------------------
// ole_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ole_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded singly linked list of signed 32-bit values with a free-slot stack.
// Indexed, find and drop-back actions walk the list, one link read per walk
// step. Throughput: one action at a time; no new request until the response
// transfers. Reset empties the list; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_list_engine
  import ole_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ole_req_if.sink    req,
  ole_rsp_if.source  rsp
);
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_WALK   = 5'd1;
  localparam logic [4:0] S_FIND   = 5'd2;
  localparam logic [4:0] S_ALLOC  = 5'd3;
  localparam logic [4:0] S_ALLOCW = 5'd4;
  localparam logic [4:0] S_PLACE  = 5'd5;
  localparam logic [4:0] S_LINKP  = 5'd6;
  localparam logic [4:0] S_LINK   = 5'd7;
  localparam logic [4:0] S_LINKW  = 5'd8;
  localparam logic [4:0] S_LINK2W = 5'd9;
  localparam logic [4:0] S_POP    = 5'd10;
  localparam logic [4:0] S_POPW   = 5'd11;
  localparam logic [4:0] S_RDE    = 5'd12;
  localparam logic [4:0] S_RDEW   = 5'd13;
  localparam logic [4:0] S_WR     = 5'd14;
  localparam logic [4:0] S_HEAD   = 5'd15;
  localparam logic [4:0] S_HEADW  = 5'd16;
  localparam logic [4:0] S_TAILW  = 5'd17;
  localparam logic [4:0] S_OUT    = 5'd18;

  localparam logic [2:0] J_FRONT  = 3'd0;
  localparam logic [2:0] J_BACK   = 3'd1;
  localparam logic [2:0] J_INS    = 3'd2;
  localparam logic [2:0] J_UNLINK = 3'd3;
  localparam logic [2:0] J_READ   = 3'd4;
  localparam logic [2:0] J_WRITE  = 3'd5;

  logic [4:0] state;
  logic [2:0] job;
  data_t      val;
  slot_t      tgt;
  cnt_t       i;
  logic       wflag;
  slot_t      s;
  slot_t      n;
  slot_t      cur;
  logic       last_rm;
  logic [2:0] status;
  data_t      rd;
  slot_t      found;
  cnt_t       count;
  slot_t      front;
  slot_t      back;
  cnt_t       sp;
  cnt_t       fresh;
  data_t      first;
  data_t      last;

  logic       ent_we, lnk_we, stk_we;
  slot_t      ent_waddr, lnk_waddr, lnk_wdata, ent_raddr, lnk_raddr, stk_raddr;
  data_t      ent_wdata, ent_rdata;
  slot_t      lnk_rdata, stk_rdata;
  slot_t      s_now;
  cnt_t       sp_m1, cnt_m1, cnt_m2;
  logic       empty, full, badidx;

  assign s_now  = wflag ? lnk_rdata : s;
  assign sp_m1  = sp - cnt_t'(1);
  assign cnt_m1 = count - cnt_t'(1);
  assign cnt_m2 = count - cnt_t'(2);
  assign empty  = (count == '0);
  assign full   = (count == cnt_t'(CAPACITY));
  assign badidx = ({1'b0, req.position} >= count);
  assign stk_raddr = sp_m1[SLOT_W-1:0];

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = s;
    ent_wdata = val;
    lnk_we    = 1'b0;
    lnk_waddr = s;
    lnk_wdata = n;
    stk_we    = 1'b0;
    ent_raddr = front;
    lnk_raddr = s;
    unique case (state)
      S_WALK:   lnk_raddr = s_now;
      S_FIND: begin
        lnk_raddr = s_now;
        ent_raddr = s_now;
      end
      S_PLACE: begin
        ent_we    = 1'b1;
        ent_waddr = n;
        lnk_we    = 1'b1;
        lnk_waddr = n;
        if (job == J_FRONT) begin
          lnk_wdata = front;
        end else if (job == J_BACK) begin
          lnk_wdata = '0;
        end else begin
          lnk_wdata = cur;
        end
      end
      S_LINKP:  lnk_we = 1'b1;
      S_LINKW:  lnk_raddr = lnk_rdata;
      S_LINK2W: begin
        lnk_we    = 1'b1;
        lnk_wdata = lnk_rdata;
        stk_we    = 1'b1;
      end
      S_POP:    lnk_raddr = front;
      S_POPW:   stk_we = 1'b1;
      S_RDE:    ent_raddr = s;
      S_WR:     ent_we = 1'b1;
      S_HEADW:  ent_raddr = back;
      default: begin
      end
    endcase
  end

  ole_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_entries (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  ole_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_links (
    .clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
    .raddr(lnk_raddr), .rdata(lnk_rdata)
  );

  ole_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free (
    .clk(clk), .we(stk_we), .waddr(sp[SLOT_W-1:0]),
    .wdata((state == S_POPW) ? front : cur),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      front <= '0;
      back  <= '0;
      sp    <= '0;
      fresh <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            val    <= req.value;
            i      <= '0;
            wflag  <= 1'b0;
            s      <= front;
            rd     <= '0;
            found  <= '0;
            status <= ST_OK;
            state  <= S_HEAD;
            case (req.action)
              A_ADD_FRONT, A_ADD_BACK: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  job   <= (req.action == A_ADD_FRONT) ? J_FRONT : J_BACK;
                  state <= S_ALLOC;
                end
              end
              A_DROP_FRONT: begin
                if (empty) status <= ST_EMPTY;
                else state <= S_POP;
              end
              A_DROP_BACK: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else if (count == cnt_t'(1)) begin
                  state <= S_POP;
                end else begin
                  job     <= J_UNLINK;
                  tgt     <= cnt_m2[SLOT_W-1:0];
                  last_rm <= 1'b1;
                  state   <= S_WALK;
                end
              end
              A_READ_AT, A_WRITE_AT: begin
                if (empty || badidx) begin
                  status <= empty ? ST_EMPTY : ST_BADIDX;
                  if (req.action == A_READ_AT) rd <= '1;
                end else begin
                  job   <= (req.action == A_READ_AT) ? J_READ : J_WRITE;
                  tgt   <= req.position;
                  state <= S_WALK;
                end
              end
              A_INSERT_AT: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else if (badidx) begin
                  status <= ST_BADIDX;
                end else if (full) begin
                  status <= ST_FULL;
                end else if (req.position == '0) begin
                  job   <= J_FRONT;
                  state <= S_ALLOC;
                end else begin
                  job   <= J_INS;
                  tgt   <= req.position - 8'd1;
                  state <= S_WALK;
                end
              end
              A_REMOVE_AT: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else if (badidx) begin
                  status <= ST_BADIDX;
                end else if (req.position == '0) begin
                  state <= S_POP;
                end else begin
                  job     <= J_UNLINK;
                  tgt     <= req.position - 8'd1;
                  last_rm <= ({1'b0, req.position} == cnt_m1);
                  state   <= S_WALK;
                end
              end
              A_FIND: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else begin
                  status <= ST_NOTFOUND;
                  state  <= S_FIND;
                end
              end
              A_CLEAR: begin
                count <= '0;
                front <= '0;
                back  <= '0;
                sp    <= '0;
                fresh <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          s <= s_now;
          if (i == {1'b0, tgt}) begin
            case (job)
              J_READ:  state <= S_RDE;
              J_WRITE: state <= S_WR;
              default: state <= S_LINK;
            endcase
          end else begin
            i     <= i + cnt_t'(1);
            wflag <= 1'b1;
          end
        end
        S_FIND: begin
          if (wflag && (ent_rdata == val)) begin
            status <= ST_OK;
            found  <= slot_t'(i - cnt_t'(1));
            state  <= S_HEAD;
          end else if (i == count) begin
            state <= S_HEAD;
          end else begin
            s     <= s_now;
            i     <= i + cnt_t'(1);
            wflag <= 1'b1;
          end
        end
        S_ALLOC: begin
          if (sp != '0) begin
            state <= S_ALLOCW;
          end else begin
            n     <= fresh[SLOT_W-1:0];
            fresh <= fresh + cnt_t'(1);
            state <= S_PLACE;
          end
        end
        S_ALLOCW: begin
          n     <= stk_rdata;
          sp    <= sp_m1;
          state <= S_PLACE;
        end
        S_PLACE: begin
          count <= count + cnt_t'(1);
          state <= S_HEAD;
          if (job == J_FRONT) begin
            front <= n;
            if (empty) back <= n;
          end else if (job == J_BACK) begin
            if (empty) begin
              front <= n;
              back  <= n;
            end else begin
              s     <= back;
              state <= S_LINKP;
            end
          end else begin
            state <= S_LINKP;
          end
        end
        S_LINKP: begin
          if (job == J_BACK) back <= n;
          state <= S_HEAD;
        end
        S_LINK:  state <= S_LINKW;
        S_LINKW: begin
          cur   <= lnk_rdata;
          state <= (job == J_INS) ? S_ALLOC : S_LINK2W;
        end
        S_LINK2W: begin
          if (last_rm) back <= s;
          sp    <= sp + cnt_t'(1);
          count <= cnt_m1;
          state <= S_HEAD;
        end
        S_POP:  state <= S_POPW;
        S_POPW: begin
          sp    <= sp + cnt_t'(1);
          count <= cnt_m1;
          if (count == cnt_t'(1)) begin
            front <= '0;
            back  <= '0;
          end else begin
            front <= lnk_rdata;
          end
          state <= S_HEAD;
        end
        S_RDE:  state <= S_RDEW;
        S_RDEW: begin
          rd    <= ent_rdata;
          state <= S_HEAD;
        end
        S_WR:    state <= S_HEAD;
        S_HEAD:  state <= S_HEADW;
        S_HEADW: begin
          first <= empty ? '0 : ent_rdata;
          state <= S_TAILW;
        end
        S_TAILW: begin
          last  <= empty ? '0 : ent_rdata;
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = (state == S_OUT);
  assign rsp.status      = status;
  assign rsp.read_value  = rd;
  assign rsp.found_index = found;
  assign rsp.list_size   = count;
  assign rsp.first_value = first;
  assign rsp.last_value  = last;
endmodule

@@ bench/ordered_list_engine_tb.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine_tb
// Self-checking bench for the ordered list engine. A queue of list actions
// feeds the request side. Each accepted action updates a shadow list in the
// bench, which gives the response to expect. Responses are checked field by
// field in order. Both sides idle at random, except near the end of the run.
// ----------------------------------------------------------------------------
module ordered_list_engine_tb;
  import ole_pkg::*;

  typedef struct {
    logic [3:0] action;
    logic [7:0] position;
    data_t      value;
  } list_op_t;

  typedef struct {
    logic [2:0] status;
    data_t      read_value;
    logic [7:0] found_index;
    logic [8:0] list_size;
    data_t      first_value;
    data_t      last_value;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ole_req_if req_ch();
  ole_rsp_if rsp_ch();

  ordered_list_engine i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  list_op_t  pending_ops[$];
  list_rsp_t expected_rsps[$];
  data_t     shadow_list[$];
  data_t     value_pool[8];
  int        mismatches = 0;
  int        checked    = 0;
  int        cycles     = 0;
  int        send_gap   = 0;
  int        recv_gap   = 0;
  int        gen_size   = 0;
  bit        calm       = 1'b0;

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("response %0d: %s got %h, expected %h", checked, field, got, want);
    mismatches++;
  endtask

  function automatic list_rsp_t apply_op(list_op_t op);
    list_rsp_t r;
    bit        empty;
    bit        full;
    bit        bad;
    r = '{ST_OK, 0, 0, 0, 0, 0};
    empty = shadow_list.size() == 0;
    full  = shadow_list.size() >= CAPACITY;
    bad   = op.position >= shadow_list.size();
    case (op.action)
      A_ADD_FRONT: begin
        if (full) r.status = ST_FULL;
        else shadow_list.push_front(op.value);
      end
      A_ADD_BACK: begin
        if (full) r.status = ST_FULL;
        else shadow_list.push_back(op.value);
      end
      A_DROP_FRONT: begin
        if (empty) r.status = ST_EMPTY;
        else void'(shadow_list.pop_front());
      end
      A_DROP_BACK: begin
        if (empty) r.status = ST_EMPTY;
        else void'(shadow_list.pop_back());
      end
      A_READ_AT: begin
        if (empty) begin
          r.status = ST_EMPTY;
          r.read_value = -1;
        end else if (bad) begin
          r.status = ST_BADIDX;
          r.read_value = -1;
        end else r.read_value = shadow_list[op.position];
      end
      A_WRITE_AT: begin
        if (empty) r.status = ST_EMPTY;
        else if (bad) r.status = ST_BADIDX;
        else shadow_list[op.position] = op.value;
      end
      A_INSERT_AT: begin
        if (empty) r.status = ST_EMPTY;
        else if (bad) r.status = ST_BADIDX;
        else if (full) r.status = ST_FULL;
        else shadow_list.insert(op.position, op.value);
      end
      A_REMOVE_AT: begin
        if (empty) r.status = ST_EMPTY;
        else if (bad) r.status = ST_BADIDX;
        else shadow_list.delete(op.position);
      end
      A_FIND: begin
        if (empty) r.status = ST_EMPTY;
        else begin
          r.status = ST_NOTFOUND;
          foreach (shadow_list[i]) begin
            if (r.status == ST_NOTFOUND && shadow_list[i] == op.value) begin
              r.status = ST_OK;
              r.found_index = i[7:0];
            end
          end
        end
      end
      A_CLEAR: shadow_list.delete();
      default: ;
    endcase
    r.list_size = 9'(shadow_list.size());
    if (shadow_list.size() != 0) begin
      r.first_value = shadow_list[0];
      r.last_value  = shadow_list[$];
    end
    return r;
  endfunction

  // rough size tracking so that random positions land mostly in range
  function automatic void queue_op(logic [3:0] a, logic [7:0] p, data_t v);
    list_op_t op;
    op = '{a, p, v};
    pending_ops.push_back(op);
    case (a)
      A_ADD_FRONT, A_ADD_BACK: if (gen_size < CAPACITY) gen_size++;
      A_INSERT_AT: if (p < gen_size && gen_size < CAPACITY) gen_size++;
      A_DROP_FRONT, A_DROP_BACK: if (gen_size > 0) gen_size--;
      A_REMOVE_AT: if (p < gen_size) gen_size--;
      A_CLEAR: gen_size = 0;
      default: ;
    endcase
  endfunction

  function automatic data_t pick_value();
    return ($urandom_range(0, 2) != 0) ? value_pool[$urandom_range(0, 7)]
                                       : data_t'($urandom);
  endfunction

  function automatic logic [7:0] pick_position();
    if (gen_size > 0 && $urandom_range(0, 5) != 0)
      return 8'($urandom_range(0, gen_size - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void queue_random_op();
    int         roll;
    logic [3:0] a;
    roll = $urandom_range(0, 99);
    if (roll < 18) a = A_ADD_BACK;
    else if (roll < 30) a = A_ADD_FRONT;
    else if (roll < 40) a = A_INSERT_AT;
    else if (roll < 48) a = A_READ_AT;
    else if (roll < 56) a = A_WRITE_AT;
    else if (roll < 64) a = A_FIND;
    else if (roll < 72) a = A_REMOVE_AT;
    else if (roll < 80) a = A_DROP_FRONT;
    else if (roll < 90) a = A_DROP_BACK;
    else if (roll < 92) a = A_CLEAR;
    else if (roll < 94) a = 4'($urandom_range(10, 15));
    else a = 4'($urandom_range(0, 15));
    queue_op(a, pick_position(), pick_value());
  endfunction

  // request side
  always @(posedge clk) begin
    list_op_t op;
    if (rst) begin
      req_ch.valid    <= 1'b0;
      req_ch.action   <= A_ADD_FRONT;
      req_ch.position <= '0;
      req_ch.value    <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_rsps.push_back(apply_op('{req_ch.action, req_ch.position,
                                           req_ch.value}));
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          op = pending_ops.pop_front();
          req_ch.action   <= op.action;
          req_ch.position <= op.position;
          req_ch.value    <= op.value;
          req_ch.valid    <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 10);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response side
  always @(posedge clk) begin
    list_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("response with no action outstanding");
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_ch.status !== want.status)
            report("status", 32'(rsp_ch.status), 32'(want.status));
          if (rsp_ch.read_value !== want.read_value)
            report("read_value", rsp_ch.read_value, want.read_value);
          if (rsp_ch.found_index !== want.found_index)
            report("found_index", 32'(rsp_ch.found_index), 32'(want.found_index));
          if (rsp_ch.list_size !== want.list_size)
            report("list_size", 32'(rsp_ch.list_size), 32'(want.list_size));
          if (rsp_ch.first_value !== want.first_value)
            report("first_value", rsp_ch.first_value, want.first_value);
          if (rsp_ch.last_value !== want.last_value)
            report("last_value", rsp_ch.last_value, want.last_value);
        end
        checked++;
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 10);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1_000_000) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    foreach (value_pool[i]) value_pool[i] = data_t'($urandom);
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = -1;
    value_pool[3] = 0;

    // empty list cases, then a short list, undefined actions and clear
    queue_op(A_DROP_FRONT, 8'd0, 0);
    queue_op(A_DROP_BACK, 8'd0, 0);
    queue_op(A_READ_AT, 8'd0, 0);
    queue_op(A_WRITE_AT, 8'd0, 5);
    queue_op(A_INSERT_AT, 8'd0, 5);
    queue_op(A_REMOVE_AT, 8'd0, 0);
    queue_op(A_FIND, 8'd0, 0);
    queue_op(A_ADD_FRONT, 8'd0, 32'sh8000_0000);
    queue_op(A_ADD_BACK, 8'd255, 32'sh7fff_ffff);
    queue_op(A_READ_AT, 8'd1, 0);
    queue_op(A_READ_AT, 8'd255, 0);
    queue_op(A_WRITE_AT, 8'd2, 9);
    queue_op(A_WRITE_AT, 8'd1, -1);
    queue_op(A_INSERT_AT, 8'd0, 11);
    queue_op(A_INSERT_AT, 8'd2, 22);
    queue_op(A_INSERT_AT, 8'd4, 33);
    queue_op(A_FIND, 8'd0, -1);
    queue_op(A_FIND, 8'd0, 12345);
    queue_op(A_REMOVE_AT, 8'd3, 0);
    queue_op(A_REMOVE_AT, 8'd9, 0);
    queue_op(A_REMOVE_AT, 8'd0, 0);
    queue_op(4'd10, 8'd0, 0);
    queue_op(4'd15, 8'hff, -1);
    queue_op(A_CLEAR, 8'd0, 0);
    queue_op(A_ADD_BACK, 8'd0, 7);
    queue_op(A_DROP_BACK, 8'd0, 0);

    repeat (280) queue_random_op();
    // fill to capacity, poke at the full list, then clear it
    while (gen_size < CAPACITY)
      queue_op($urandom_range(0, 1) ? A_ADD_BACK : A_ADD_FRONT, 8'd0, pick_value());
    queue_op(A_ADD_FRONT, 8'd0, 1);
    queue_op(A_ADD_BACK, 8'd0, 2);
    queue_op(A_INSERT_AT, 8'd255, 3);
    queue_op(A_INSERT_AT, 8'd0, 3);
    queue_op(A_READ_AT, 8'd255, 0);
    queue_op(A_FIND, 8'd0, value_pool[7]);
    queue_op(A_DROP_BACK, 8'd0, 0);
    queue_op(A_INSERT_AT, 8'd254, 4);
    queue_op(A_REMOVE_AT, 8'd255, 0);
    repeat (20) queue_random_op();
    queue_op(A_CLEAR, 8'd0, 0);
    repeat (280) queue_random_op();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending_ops.size() > 120) @(posedge clk);
    calm = 1'b1;
    while (pending_ops.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d responses checked over %0d cycles, including a full list", checked,
             cycles);
    $display("and every action on empty, in-range and out-of-range positions");
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
